// File: src/sti_pkg.sv
package sti_pkg;

  localparam int ArgW        = 20;
  localparam int ArgFrac     = 12;
  localparam int OutW        = 16;
  localparam int ValW        = 32;
  localparam int SlopeW      = ValW + 1;
  localparam int TaylorTerms = 20;
  // Rounding divides by the table span times 2^16, that is Limit times 2^(16 + ArgFrac).
  localparam int RoundShift  = OutW + ArgFrac;

  // Unsigned quotient by restoring long division, for the table constants.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-r) for r in [0, 1], both in Q1.31, by a truncated Taylor series.
  function automatic longint exp_neg_frac(longint r31);
    longint term;
    longint sum;
    term = longint'(1) << 31;
    sum  = term;
    for (int k = 1; k <= TaylorTerms; k++) begin
      term = longint'(udiv64(64'((term * r31) >>> 31), 64'(k)));
      if ((k & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Table sample idx of the sigmoid in Q0.32, evaluated at elaboration.
  function automatic logic [ValW-1:0] sample_val(int idx, int entries, int limit);
    longint      e_inv;
    longint      num;
    longint      den;
    longint      n;
    longint      rem;
    longint      r31;
    longint      e;
    logic [63:0] d;
    logic [63:0] f;
    e_inv = exp_neg_frac(longint'(1) << 31);
    den   = longint'(entries - 1);
    num   = longint'(idx) * longint'(limit);
    n     = longint'(udiv64(64'(num), 64'(den)));
    rem   = num - n * den;
    r31   = longint'(udiv64(64'(rem << 31), 64'(den)));
    e     = exp_neg_frac(r31);
    for (longint k = 0; k < n; k++) begin
      e = (e * e_inv) >>> 31;
    end
    if (e < 0) begin
      e = 0;
    end
    d = (64'd1 << 31) + 64'(e);
    f = udiv64((64'd1 << 63) + (d >> 1), d);
    if (f > 64'hFFFF_FFFF) begin
      f = 64'hFFFF_FFFF;
    end
    return f[ValW-1:0];
  endfunction

endpackage

// File: src/sigmoid_table_interpolator_unit.sv
// Throughput: one word per cycle; the pipeline only holds when the output stalls.
// The index path (3 stages), the sample table read (1 stage) and the interpolation
// and rounding path (6 stages) are all registered; a stall freezes every stage.
// Reset clears the stage valid bits only; the sample table is fixed at build time.
module sigmoid_table_interpolator_unit import sti_pkg::*; #(
  parameter int TableEntries = 1024,
  parameter int InputLimit   = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic signed [ArgW-1:0] argument_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic [OutW-1:0]        sigmoid_value_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i
);

  localparam int Latency = 10;
  localparam int AddrW   = $clog2(TableEntries);
  localparam int QW      = $clog2(InputLimit << ArgFrac);

  logic                     en;
  logic [Latency-1:0]       vld_q;
  logic [Latency-1:0]       vld_d;
  logic [AddrW-1:0]         addr;
  logic [QW-1:0]            frac;
  logic                     neg;
  logic [ValW-1:0]          val;
  logic signed [SlopeW-1:0] slope;

  // The whole pipeline moves unless a finished word is held at the output.
  assign en         = !(vld_q[Latency-1] && out_stall_i);
  assign in_stall_o = !en;
  assign vld_d      = {vld_q[Latency-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  sti_index #(
    .Entries (TableEntries),
    .Limit   (InputLimit)
  ) u_index (
    .clk_i      (clk_i),
    .en_i       (en),
    .argument_i (argument_i),
    .addr_o     (addr),
    .frac_o     (frac),
    .neg_o      (neg)
  );

  sti_rom #(
    .Entries (TableEntries),
    .Limit   (InputLimit)
  ) u_rom (
    .clk_i   (clk_i),
    .en_i    (en),
    .addr_i  (addr),
    .val_o   (val),
    .slope_o (slope)
  );

  sti_interp #(
    .Limit (InputLimit)
  ) u_interp (
    .clk_i           (clk_i),
    .en_i            (en),
    .val_i           (val),
    .slope_i         (slope),
    .frac_i          (frac),
    .neg_i           (neg),
    .sigmoid_value_o (sigmoid_value_o)
  );

  assign out_valid_o = vld_q[Latency-1];

endmodule

// File: src/sti_rom.sv
module sti_rom import sti_pkg::*; #(
  parameter int Entries = 1024,
  parameter int Limit   = 8,
  localparam int AddrW  = $clog2(Entries)
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [AddrW-1:0]         addr_i,
  output logic [ValW-1:0]          val_o,
  output logic signed [SlopeW-1:0] slope_o
);

  logic [ValW-1:0]          val_tbl   [Entries];
  logic signed [SlopeW-1:0] slope_tbl [Entries];
  logic [ValW-1:0]          val_q;
  logic signed [SlopeW-1:0] slope_q;

  // Sample values and forward differences are fixed when the design is built.
  for (genvar g = 0; g < Entries; g++) begin : g_entry
    localparam logic [ValW-1:0] Cur = sample_val(g, Entries, Limit);
    localparam logic [ValW-1:0] Nxt = (g + 1 < Entries) ? sample_val(g + 1, Entries, Limit)
                                                         : Cur;
    assign val_tbl[g]   = Cur;
    assign slope_tbl[g] = $signed({1'b0, Nxt}) - $signed({1'b0, Cur});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q   <= val_tbl[addr_i];
      slope_q <= slope_tbl[addr_i];
    end
  end

  assign val_o   = val_q;
  assign slope_o = slope_q;

endmodule

// File: src/sti_index.sv
module sti_index import sti_pkg::*; #(
  parameter int Entries = 1024,
  parameter int Limit   = 8,
  localparam int AddrW  = $clog2(Entries),
  localparam int QW     = $clog2(Limit << ArgFrac)
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [ArgW-1:0] argument_i,
  output logic [AddrW-1:0]       addr_o,
  output logic [QW-1:0]          frac_o,
  output logic                   neg_o
);

  localparam int Q  = Limit << ArgFrac;
  localparam int PW = QW + AddrW;
  localparam int SW = PW - ArgFrac;
  // Quotient by Limit through a rounded-up reciprocal, exact for all SW-bit values.
  localparam int K  = SW + $clog2(Limit);
  localparam int MW = K + 1;
  localparam logic [MW-1:0] Recip = MW'(((64'd1 << K) + 64'(Limit) - 64'd1) / 64'(Limit));

  logic [ArgW-1:0]   raw;
  logic [ArgW-1:0]   mag_d;
  logic              sat_d;
  logic [QW-1:0]     mag1_q;
  logic              neg1_q;
  logic              sat1_q;
  logic [PW-1:0]     p2_q;
  logic              neg2_q;
  logic              sat2_q;
  logic [SW+MW-1:0]  prod_d;
  logic [AddrW-1:0]  q3_q;
  logic [PW-1:0]     p3_q;
  logic              neg3_q;
  logic              sat3_q;
  logic [PW-1:0]     fr_full;
  logic [QW-1:0]     frac_d;
  logic [QW-1:0]     frac4_q;
  logic              neg4_q;

  assign raw   = argument_i;
  assign mag_d = raw[ArgW-1] ? (~raw) + ArgW'(1) : raw;
  // Any magnitude of at least the table span lands on the last sample.
  assign sat_d = mag_d >= ArgW'(Q);

  assign prod_d  = (SW+MW)'(p2_q[PW-1:ArgFrac]) * (SW+MW)'(Recip);
  assign fr_full = p3_q - PW'(q3_q) * PW'(Q);
  assign addr_o  = sat3_q ? AddrW'(Entries - 1) : q3_q;
  assign frac_d  = sat3_q ? '0 : fr_full[QW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= mag_d[QW-1:0];
      neg1_q  <= raw[ArgW-1];
      sat1_q  <= sat_d;
      p2_q    <= PW'(mag1_q) * PW'(Entries - 1);
      neg2_q  <= neg1_q;
      sat2_q  <= sat1_q;
      q3_q    <= prod_d[K +: AddrW];
      p3_q    <= p2_q;
      neg3_q  <= neg2_q;
      sat3_q  <= sat2_q;
      frac4_q <= frac_d;
      neg4_q  <= neg3_q;
    end
  end

  assign frac_o = frac4_q;
  assign neg_o  = neg4_q;

endmodule

// File: src/sti_interp.sv
module sti_interp import sti_pkg::*; #(
  parameter int Limit  = 8,
  localparam int QW    = $clog2(Limit << ArgFrac)
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [ValW-1:0]          val_i,
  input  logic signed [SlopeW-1:0] slope_i,
  input  logic [QW-1:0]            frac_i,
  input  logic                     neg_i,
  output logic [OutW-1:0]          sigmoid_value_o
);

  localparam int Q    = Limit << ArgFrac;
  localparam int LimW = $clog2(Limit + 1);
  localparam int AW   = ValW + LimW;
  localparam int BW   = SlopeW + QW + 1;
  localparam int CW   = ValW + QW + 1;
  localparam int VW   = CW + 1;
  localparam int WW   = CW + 1 - RoundShift;
  localparam int YW   = OutW + 1;
  localparam int K    = WW + $clog2(Limit);
  localparam int MW   = K + 1;
  localparam logic [MW-1:0] Recip = MW'(((64'd1 << K) + 64'(Limit) - 64'd1) / 64'(Limit));
  localparam logic [CW-1:0] Full  = CW'(Q) << ValW;
  localparam logic [CW:0]   Half  = (CW+1)'(Limit) << (RoundShift - 1);

  logic signed [BW-1:0] slope_x;
  logic signed [BW-1:0] frac_x;
  logic [AW-1:0]        pa_q;
  logic signed [BW-1:0] pb_q;
  logic                 neg_a_q;
  logic signed [VW-1:0] v_d;
  logic [CW-1:0]        vc_d;
  logic [CW-1:0]        vc_q;
  logic                 neg_b_q;
  logic [CW-1:0]        vn_q;
  logic [CW:0]          rnd_d;
  logic [WW-1:0]        w_q;
  logic [WW+MW-1:0]     prod_d;
  logic [YW-1:0]        y_q;
  logic [OutW-1:0]      out_q;

  assign slope_x = BW'(slope_i);
  assign frac_x  = BW'({1'b0, frac_i});

  // Interpolated value, still scaled by the table span; clamp to [0, 1.0].
  assign v_d = $signed(VW'({pa_q, ArgFrac'(0)})) + VW'(pb_q);

  always_comb begin
    if (v_d < 0) begin
      vc_d = '0;
    end else if (v_d > $signed(VW'(Full))) begin
      vc_d = Full;
    end else begin
      vc_d = CW'(v_d);
    end
  end

  assign rnd_d  = (CW+1)'(vn_q) + Half;
  assign prod_d = (WW+MW)'(w_q) * (WW+MW)'(Recip);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q    <= AW'(val_i) * AW'(Limit);
      pb_q    <= slope_x * frac_x;
      neg_a_q <= neg_i;
      vc_q    <= vc_d;
      neg_b_q <= neg_a_q;
      vn_q    <= neg_b_q ? Full - vc_q : vc_q;
      w_q     <= rnd_d[RoundShift +: WW];
      y_q     <= prod_d[K +: YW];
      out_q   <= y_q[OutW] ? '1 : y_q[OutW-1:0];
    end
  end

  assign sigmoid_value_o = out_q;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top import sti_pkg::*; ;

  localparam int Entries    = 1024;
  localparam int Limit      = 8;
  localparam longint SpanQ  = longint'(Limit) << ArgFrac;
  localparam int RandItems  = 1500;
  localparam int HoldAt     = 600;
  localparam int DrainAt    = 1000;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [ArgW-1:0] arg;
    logic            known;
    logic [OutW-1:0] value;
  } arg_row_t;

  typedef struct {
    logic [ArgW-1:0] arg;
    logic [OutW-1:0] value;
  } sigmoid_exp_t;

  // Only sigmoid(0) = one half is typed in; every other row goes through the predictor.
  localparam int DirCount = 17;
  localparam arg_row_t DirRows [DirCount] = '{
    '{20'h00000, 1'b1, 16'h8000},
    '{20'h00001, 1'b0, 16'h0000},
    '{20'hFFFFF, 1'b0, 16'h0000},
    '{20'h7FFFF, 1'b0, 16'h0000},
    '{20'h80000, 1'b0, 16'h0000},
    '{20'h07FFF, 1'b0, 16'h0000},
    '{20'h08000, 1'b0, 16'h0000},
    '{20'hF8000, 1'b0, 16'h0000},
    '{20'hF8001, 1'b0, 16'h0000},
    '{20'h08001, 1'b0, 16'h0000},
    '{20'h01000, 1'b0, 16'h0000},
    '{20'hFF000, 1'b0, 16'h0000},
    '{20'h00800, 1'b0, 16'h0000},
    '{20'h00020, 1'b0, 16'h0000},
    '{20'h00021, 1'b0, 16'h0000},
    '{20'h55555, 1'b0, 16'h0000},
    '{20'hAAAAA, 1'b0, 16'h0000}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic signed [ArgW-1:0] argument_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [OutW-1:0]        sigmoid_value_o;
  logic                   out_valid_o;
  logic                   out_stall_i;

  bit [31:0]    sig_rom   [Entries];
  longint       sig_slope [Entries];
  sigmoid_exp_t sigmoid_expq [$];
  bit           hold_off_req = 1'b0;
  int           errors       = 0;
  int           words_seen   = 0;
  int           neg_count    = 0;
  int           stall_cycles = 0;
  int           cycle_count  = 0;

  sigmoid_table_interpolator_unit #(
    .TableEntries(Entries),
    .InputLimit  (Limit)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .argument_i     (argument_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sigmoid_value_o(sigmoid_value_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // exp(-x) for x in [0, 1] in Q1.31, 20-term Taylor series with truncating steps.
  function automatic longint series_exp_neg(longint x31);
    longint term;
    longint sum;
    term = longint'(1) <<< 31;
    sum  = term;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * x31) >>> 31) / k;
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic void build_sigmoid_rom();
    longint    e_one;
    longint    num;
    longint    whole;
    longint    rem;
    longint    x31;
    longint    e;
    bit [63:0] d;
    bit [63:0] f;
    e_one = series_exp_neg(longint'(1) <<< 31);
    for (int i = 0; i < Entries; i++) begin
      num   = longint'(i) * Limit;
      whole = num / (Entries - 1);
      rem   = num % (Entries - 1);
      x31   = (rem <<< 31) / (Entries - 1);
      e     = series_exp_neg(x31);
      for (longint k = 0; k < whole; k++) begin
        e = (e * e_one) >>> 31;
      end
      if (e < 0) begin
        e = 0;
      end
      d = (64'd1 << 31) + 64'(e);
      f = ((64'd1 << 63) + (d >> 1)) / d;
      if (f > 64'hFFFF_FFFF) begin
        f = 64'hFFFF_FFFF;
      end
      sig_rom[i] = f[31:0];
    end
    for (int i = 0; i < Entries; i++) begin
      sig_slope[i] = (i + 1 < Entries) ?
                     longint'(sig_rom[i + 1]) - longint'(sig_rom[i]) : 0;
    end
  endfunction

  function automatic logic [OutW-1:0] predict_sigmoid(logic [ArgW-1:0] a);
    logic [ArgW-1:0] mag;
    longint          p;
    longint          idx;
    longint          v;
    longint          full;
    longint          y;
    mag  = a[ArgW-1] ? (~a + 1'b1) : a;
    full = SpanQ <<< 32;
    p    = longint'(mag) * (Entries - 1);
    idx  = p / SpanQ;
    if (idx >= Entries - 1) begin
      v = longint'(sig_rom[Entries-1]) * SpanQ;
    end else begin
      v = longint'(sig_rom[idx]) * SpanQ + sig_slope[idx] * (p % SpanQ);
    end
    if (v < 0) begin
      v = 0;
    end
    if (v > full) begin
      v = full;
    end
    // Negative arguments mirror around one half.
    if (a[ArgW-1]) begin
      v = full - v;
    end
    y = (v + (SpanQ <<< 15)) / (SpanQ <<< 16);
    if (y > 65535) begin
      y = 65535;
    end
    return y[OutW-1:0];
  endfunction

  // Most arguments land in the interpolated range, where the table actually matters.
  function automatic logic [ArgW-1:0] random_argument();
    logic [ArgW-1:0] mag;
    int              pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      mag = ArgW'($urandom_range(0, 32767));
    end else if (pick < 65) begin
      mag = ArgW'($urandom_range(32768 - 64, 32768 + 64));
    end else if (pick < 75) begin
      mag = ArgW'($urandom_range(0, 255));
    end else begin
      return ArgW'($urandom);
    end
    return ($urandom_range(0, 1) == 1) ? (~mag + 1'b1) : mag;
  endfunction

  function automatic int draw_wait(int mode);
    if (mode == 0) begin
      return 0;
    end else if (mode == 1) begin
      return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    end
    return $urandom_range(0, 18);
  endfunction

  initial begin : sender
    logic [ArgW-1:0] a;
    logic [OutW-1:0] want;
    int              gap;
    int              tx_mode;
    int              burst_left;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    argument_i = '0;
    tx_mode    = 0;
    burst_left = 0;
    build_sigmoid_rom();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < DirCount + RandItems; i++) begin
      a = (i < DirCount) ? DirRows[i].arg : random_argument();
      if (i % 50 == 0) begin
        tx_mode = $urandom_range(0, 2);
      end
      // Back-to-back words while the receiver holds off, so the pipeline fills up.
      if (i == HoldAt) begin
        hold_off_req = 1'b1;
        burst_left   = 60;
      end
      if (i == DrainAt) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (sigmoid_expq.size() != 0) @(posedge clk_i);
      end
      gap = (burst_left > 0) ? 0 : draw_wait(tx_mode);
      if (burst_left > 0) begin
        burst_left--;
      end
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      argument_i <= a;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      if (i < DirCount && DirRows[i].known) begin
        want = DirRows[i].value;
      end else begin
        want = predict_sigmoid(a);
      end
      sigmoid_expq.push_back('{arg: a, value: want});
      if (a[ArgW-1]) begin
        neg_count++;
      end
    end
    in_valid_i <= 1'b0;
    while (sigmoid_expq.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d arguments (%0d directed, %0d negative), checked %0d sigmoid words.",
             DirCount + RandItems, DirCount, neg_count, words_seen);
    $display("Input was held off for %0d cycles; %0d errors found.", stall_cycles, errors);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : receiver
    int hold;
    int rx_mode;
    int words;
    out_stall_i = 1'b0;
    rx_mode     = 0;
    words       = 0;
    forever begin
      if (words % 64 == 0) begin
        rx_mode = $urandom_range(0, 2);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold         = 250;
      end else begin
        hold = draw_wait(rx_mode);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      words++;
    end
  end

  always @(posedge clk_i) begin
    sigmoid_exp_t oldest;
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d words outstanding.",
               cycle_count, sigmoid_expq.size());
      $display("tb_top NOT OK");
      $finish;
    end
    if (in_valid_i && in_stall_o) begin
      stall_cycles++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_seen++;
      if (sigmoid_expq.size() == 0) begin
        $display("%0t: unexpected sigmoid word, expected none, got %h", $time,
                 sigmoid_value_o);
        errors++;
      end else begin
        oldest = sigmoid_expq.pop_front();
        if (sigmoid_value_o !== oldest.value) begin
          $display("%0t: sigmoid of argument %h, expected %h, got %h", $time,
                   oldest.arg, oldest.value, sigmoid_value_o);
          errors++;
        end
      end
    end
  end

endmodule
